/* rtl/sorted_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// sorted_priority_queue_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check that cons holds in the same cycle as ant; disabled during reset.
`define SPQ_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ant; disabled during reset.
`define SPQ_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  // Queue depth; must be a power of two since entries live in a ring buffer.
  localparam int QUEUE_DEPTH = 256;
  localparam int HANDLE_BITS = 10;

  localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the stream beats
  localparam int COUNT_W  = 32;
  localparam int LABEL_W  = 8;
  localparam int HANDLE_W = 10;
  localparam int OCC_W    = 9;

  localparam int IN_LABEL_LSB   = COUNT_W;
  localparam int IN_HANDLE_LSB  = COUNT_W + LABEL_W;
  localparam int IN_FIELDS_W    = COUNT_W + LABEL_W + HANDLE_W;
  localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W     = 1;

  localparam int OUT_FIELDS_W   = COUNT_W + LABEL_W + HANDLE_W + OCC_W;
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W    = 2;

  // Command codes carried on the input tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic [LABEL_W-1:0]     label;
    logic [HANDLE_BITS-1:0] handle;
  } spq_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the incoming beat, clear the result
    logic rd_idx;     // read entry at the scan index
    logic rd_prev;    // read entry just below the scan index
    logic rd_head;    // read the head entry
    logic shift;      // move the read entry up by one, step the index down
    logic put_above;  // write the new entry just above the scan index
    logic put_head;   // write the new entry at the head slot
    logic pop;        // take the read entry as the result, drop the head
    logic emit;       // move the result into the output register
  } spq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic gt;         // read entry sorts after the new entry
    logic idx_zero;
    logic out_free;
  } spq_status_t;

endpackage

/* rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded sorted queue of (count, label, handle) entries, smallest key at the
// head; ties on count break on the unsigned label, equal keys stay in arrival
// order. One command beat is taken at a time. A pop reads the head entry,
// captures it as the result and hands it to the output register. An insert
// scans down from the tail, moving larger entries up one slot per cycle
// through the single write port of the entry memory, then writes the new
// entry above them; into an empty queue it writes the head slot. Empty pops
// and full inserts go straight to the result. Entries sit in a ring buffer,
// so a pop only advances the head. The result waits in an output register;
// a new beat is accepted while it is still pending, and the next result
// waits in the sequencer's last state until the sink takes the pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key_count [31:0], key_label [39:32], node_handle [49:40], zero pad
  input  logic [spq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // command [0]
  input  logic [spq_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_count [31:0], out_label [39:32], out_handle [49:40],
  // occupancy [58:50], zero pad
  output logic [spq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // popped_valid [0], overflow [1]
  output logic [spq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import spq_pkg::*;

  spq_cmd_t    cmd;
  spq_status_t status;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage and result path
  spq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_data_i (s_axis_tdata),
    .item_cmd_i  (s_axis_tuser[0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_user_o  (m_axis_tuser)
  );

endmodule

/* rtl/spq_dpath.sv */
// ----------------------------------------------------------------------------
// spq_dpath
// Entry memory (ring buffer), scan index, fill level and the result and
// output registers of the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [spq_pkg::IN_TDATA_W-1:0]   item_data_i,
  input  logic                             item_cmd_i,
  input  spq_pkg::spq_cmd_t                cmd_i,
  output spq_pkg::spq_status_t             status_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [spq_pkg::OUT_TDATA_W-1:0]  res_data_o,
  output logic [spq_pkg::OUT_TUSER_W-1:0]  res_user_o
);
  import spq_pkg::*;

  spq_entry_t              mem [QUEUE_DEPTH];
  spq_entry_t              rdata_q;
  spq_entry_t              new_q;
  spq_entry_t              in_entry;
  logic [FILL_W-1:0]       fill_q;
  logic [ADDR_W-1:0]       head_q;
  logic [ADDR_W-1:0]       idx_q;

  logic                    st_valid_q;
  logic                    st_ovf_q;
  spq_entry_t              st_entry_q;

  logic                    out_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic [OUT_TUSER_W-1:0]  out_user_q;
  logic [OUT_TDATA_W-1:0]  out_data_d;

  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  spq_entry_t              wr_data;
  logic                    empty;
  logic                    full;
  logic                    out_free;

  // Unpack the incoming beat
  always_comb begin
    in_entry.count  = item_data_i[COUNT_W-1:0];
    in_entry.label  = item_data_i[IN_LABEL_LSB +: LABEL_W];
    in_entry.handle = HANDLE_BITS'(item_data_i[IN_HANDLE_LSB +: HANDLE_W]);
  end

  assign empty    = (fill_q == '0);
  assign full     = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign out_free = !out_valid_q || res_ready_i;

  // Memory addressing: logical positions are offsets from the head slot
  always_comb begin
    rd_en   = cmd_i.rd_idx || cmd_i.rd_prev || cmd_i.rd_head;
    rd_addr = head_q + idx_q;
    if (cmd_i.rd_head) begin
      rd_addr = head_q;
    end else if (cmd_i.rd_prev) begin
      rd_addr = head_q + idx_q - 1'b1;
    end
    wr_en   = cmd_i.shift || cmd_i.put_above || cmd_i.put_head;
    wr_addr = cmd_i.put_head ? head_q : ADDR_W'(head_q + idx_q + 1'b1);
    wr_data = cmd_i.shift ? rdata_q : new_q;
  end

  // Entry storage with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Hold the entry to insert
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_q <= in_entry;
    end
  end

  // Fill level, head slot and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      head_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= ADDR_W'(fill_q - 1'b1);
      end else if (cmd_i.shift) begin
        idx_q <= idx_q - 1'b1;
      end
      if (cmd_i.put_above || cmd_i.put_head) begin
        fill_q <= fill_q + 1'b1;
      end else if (cmd_i.pop) begin
        fill_q <= fill_q - 1'b1;
        head_q <= head_q + 1'b1;
      end
    end
  end

  // Result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_valid_q <= 1'b0;
      st_ovf_q   <= (item_cmd_i == CMD_INSERT) && full;
      st_entry_q <= '0;
    end else if (cmd_i.pop) begin
      st_valid_q <= 1'b1;
      st_entry_q <= rdata_q;
    end
  end

  // Pack the result beat, occupancy taken after the update
  assign out_data_d = OUT_TDATA_W'({OCC_W'(fill_q), HANDLE_W'(st_entry_q.handle),
                                    st_entry_q.label, st_entry_q.count});

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= out_data_d;
      out_user_q <= {st_ovf_q, st_valid_q};
    end
  end

  assign status_o.empty    = empty;
  assign status_o.full     = full;
  assign status_o.gt       = (rdata_q.count > new_q.count) ||
                             ((rdata_q.count == new_q.count) &&
                              (rdata_q.label > new_q.label));
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.out_free = out_free;

  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_data_q;
  assign res_user_o  = out_user_q;

  `SPQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_W'(QUEUE_DEPTH), "fill level beyond depth")
  `SPQ_ASSERT_IMP(a_pop_not_empty, cmd_i.pop, !empty, "pop from empty queue")
  `SPQ_ASSERT_IMP(a_emit_free, cmd_i.emit, out_free, "result overwrites pending beat")
  `SPQ_ASSERT_NXT(a_put_grows, cmd_i.put_above || cmd_i.put_head, fill_q == FILL_W'($past(fill_q) + 1'b1), "insert did not grow fill level")

endmodule

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the sorted priority queue: accepts one beat, walks the
// insert scan or the pop read, then hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  output logic                  in_ready_o,
  input  spq_pkg::spq_status_t  status_i,
  output spq_pkg::spq_cmd_t     cmd_o
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD       = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_PUT_HEAD = 3'd3;
  localparam logic [2:0] S_POP_RD   = 3'd4;
  localparam logic [2:0] S_POP_CAP  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_cmd_i == CMD_POP) begin
            state_d = status_i.empty ? S_DONE : S_POP_RD;
          end else if (status_i.full) begin
            state_d = S_DONE;
          end else if (status_i.empty) begin
            state_d = S_PUT_HEAD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        // Shift larger entries up one slot until the new entry fits
        if (status_i.gt) begin
          cmd_o.shift = 1'b1;
          if (status_i.idx_zero) begin
            state_d = S_PUT_HEAD;
          end else begin
            cmd_o.rd_prev = 1'b1;
          end
        end else begin
          cmd_o.put_above = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_PUT_HEAD: begin
        cmd_o.put_head = 1'b1;
        state_d        = S_DONE;
      end
      S_POP_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_POP_CAP;
      end
      S_POP_CAP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
